// ----- hdl/mtt_pkg.sv -----
// Shared constants, character codes and the command word type of the markup tag tokenizer.
package mtt_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int CNT_W = 8;
  localparam int Q_DEPTH = 2;

  localparam logic [2:0] K_TEXT   = 3'd0;
  localparam logic [2:0] K_NAME   = 3'd1;
  localparam logic [2:0] K_BARE   = 3'd2;
  localparam logic [2:0] K_ATTR   = 3'd3;
  localparam logic [2:0] K_VALUE  = 3'd4;
  localparam logic [2:0] K_CLOSE  = 3'd5;
  localparam logic [2:0] K_DONE   = 3'd6;
  localparam logic [2:0] K_STATUS = 3'd7;

  localparam logic [1:0] ST_CLEAN  = 2'd0;
  localparam logic [1:0] ST_SYNTAX = 2'd1;
  localparam logic [1:0] ST_UNEXP  = 2'd2;
  localparam logic [1:0] ST_OVER   = 2'd3;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // A command first drains the buffer, then gives an event or stores one character.
  typedef struct packed {
    logic             wr;
    logic [CNT_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             drain;
    logic [2:0]       dkind;
    logic [CNT_W-1:0] dcount;
    logic             ev;
    logic [2:0]       ekind;
    logic [1:0]       estatus;
  } cmd_t;

endpackage

// ----- hdl/mtt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module mtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/mtt_front.sv -----
// Front end: accepts input words, tracks the parse mode and fill count, and issues commands.
module mtt_front import mtt_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] in_char,
  output logic       q_push,
  output cmd_t       q_data,
  input  logic       q_full
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] CAP = AW'(BUFFER_DEPTH - 1);

  localparam logic [2:0] MODE_TEXT  = 3'd0;
  localparam logic [2:0] MODE_NAME  = 3'd1;
  localparam logic [2:0] MODE_ATTR  = 3'd2;
  localparam logic [2:0] MODE_CLOSE = 3'd3;
  localparam logic [2:0] MODE_VALUE = 3'd4;

  logic [2:0]    mode;
  logic [2:0]    mode_next;
  logic [AW-1:0] fill;
  logic [AW-1:0] fill_next;
  logic          full;
  logic          app;
  logic          accept;
  cmd_t          c;

  assign full     = (fill == CAP);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_data   = c;
  assign q_push   = accept && (c.wr || c.drain || c.ev);

  always_comb begin
    c         = '0;
    mode_next = mode;
    fill_next = fill;
    app       = 1'b0;
    if (cmd) begin
      c.ev = 1'b1;
      c.ekind = K_STATUS;
      if (mode != MODE_TEXT) begin
        c.estatus = ST_UNEXP;
      end else begin
        c.estatus = ST_CLEAN;
        c.drain   = (fill != '0);
        c.dkind   = K_TEXT;
        c.dcount  = CNT_W'(fill);
        fill_next = '0;
      end
    end else begin
      case (mode)
        MODE_TEXT: begin
          if (in_char == CH_LT) begin
            c.drain   = (fill != '0);
            c.dkind   = K_TEXT;
            c.dcount  = CNT_W'(fill);
            fill_next = '0;
            mode_next = MODE_NAME;
          end else if (full) begin
            c.drain   = 1'b1;
            c.dkind   = K_TEXT;
            c.dcount  = CNT_W'(CAP);
            c.wr      = 1'b1;
            c.waddr   = '0;
            c.wdata   = in_char;
            fill_next = AW'(1);
          end else begin
            app = 1'b1;
          end
        end
        MODE_NAME: begin
          if (in_char == CH_SLASH) begin
            if (fill != '0) begin
              c.ev      = 1'b1;
              c.ekind   = K_STATUS;
              c.estatus = ST_SYNTAX;
            end else begin
              mode_next = MODE_CLOSE;
            end
          end else if (in_char == CH_GT || in_char == CH_SPACE) begin
            c.drain   = 1'b1;
            c.dkind   = K_NAME;
            c.dcount  = CNT_W'(fill);
            fill_next = '0;
            if (in_char == CH_GT) begin
              c.ev      = 1'b1;
              c.ekind   = K_DONE;
              mode_next = MODE_TEXT;
            end else begin
              mode_next = MODE_ATTR;
            end
          end else begin
            app = 1'b1;
          end
        end
        MODE_ATTR: begin
          if (in_char == CH_SPACE || in_char == CH_GT) begin
            c.drain   = 1'b1;
            c.dkind   = K_BARE;
            c.dcount  = CNT_W'(fill);
            fill_next = '0;
            if (in_char == CH_GT) begin
              c.ev      = 1'b1;
              c.ekind   = K_DONE;
              mode_next = MODE_TEXT;
            end
          end else if (in_char == CH_EQ) begin
            c.drain   = 1'b1;
            c.dkind   = K_ATTR;
            c.dcount  = CNT_W'(fill);
            fill_next = '0;
            mode_next = MODE_VALUE;
          end else begin
            app = 1'b1;
          end
        end
        MODE_CLOSE: begin
          if (in_char == CH_GT) begin
            c.drain   = 1'b1;
            c.dkind   = K_CLOSE;
            c.dcount  = CNT_W'(fill);
            fill_next = '0;
            mode_next = MODE_TEXT;
          end else begin
            app = 1'b1;
          end
        end
        MODE_VALUE: begin
          if (in_char == CH_SPACE || in_char == CH_GT) begin
            c.drain   = 1'b1;
            c.dkind   = K_VALUE;
            c.dcount  = CNT_W'(fill);
            fill_next = '0;
            if (in_char == CH_GT) begin
              c.ev      = 1'b1;
              c.ekind   = K_DONE;
              mode_next = MODE_TEXT;
            end else begin
              mode_next = MODE_ATTR;
            end
          end else begin
            app = 1'b1;
          end
        end
        default: begin
          c.ev      = 1'b1;
          c.ekind   = K_STATUS;
          c.estatus = ST_SYNTAX;
          mode_next = MODE_TEXT;
          fill_next = '0;
        end
      endcase
    end
    if (app) begin
      if (full) begin
        c.ev      = 1'b1;
        c.ekind   = K_STATUS;
        c.estatus = ST_OVER;
      end else begin
        c.wr      = 1'b1;
        c.waddr   = CNT_W'(fill);
        c.wdata   = in_char;
        fill_next = fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TEXT;
      fill <= '0;
    end else if (accept) begin
      mode <= mode_next;
      fill <= fill_next;
    end
  end

endmodule

// ----- hdl/mtt_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
module mtt_cmd_fifo import mtt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic pop_valid
);

  localparam int QAW = $clog2(Q_DEPTH);
  localparam logic [QAW:0] QFULL = (QAW + 1)'(Q_DEPTH);

  cmd_t           entries [Q_DEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == QFULL);
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/mtt_back.sv -----
// Back end: stores token characters and drains the buffer and events into the output register.
module mtt_back import mtt_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic       has_char,
  output logic [7:0] out_char,
  output logic       token_end,
  output logic [1:0] status,
  output logic       last
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;
  localparam logic [1:0] S_EVENT = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  cmd_t          cur;
  cmd_t          cur_next;
  logic [AW-1:0] idx;
  logic [AW-1:0] idx_next;
  logic [AW-1:0] cnt;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;
  logic          can_load;
  logic          load;
  logic          fin;
  logic [2:0]    ld_kind;
  logic          ld_has;
  logic [7:0]    ld_char;
  logic          ld_end;
  logic [1:0]    ld_status;
  logic          ld_last;

  assign cnt      = cur.dcount[AW-1:0];
  assign can_load = !out_valid || !out_stall;

  mtt_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_next),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    cur_next   = cur;
    idx_next   = idx;
    q_pop      = 1'b0;
    we         = 1'b0;
    waddr      = cur.waddr[AW-1:0];
    wdata      = cur.wdata;
    load       = 1'b0;
    fin        = 1'b0;
    ld_kind    = K_TEXT;
    ld_has     = 1'b0;
    ld_char    = '0;
    ld_end     = 1'b0;
    ld_status  = ST_CLEAN;
    ld_last    = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cur_next = q_data;
          idx_next = '0;
          if (q_data.drain) begin
            state_next = S_DRAIN;
          end else if (q_data.ev) begin
            state_next = S_EVENT;
          end else begin
            we    = q_data.wr;
            waddr = q_data.waddr[AW-1:0];
            wdata = q_data.wdata;
          end
        end
      end
      S_DRAIN: begin
        if (can_load) begin
          load    = 1'b1;
          ld_kind = cur.dkind;
          if (cnt == '0) begin
            fin = 1'b1;
          end else begin
            ld_has  = 1'b1;
            ld_char = rdata;
            fin     = (idx == cnt - 1'b1);
          end
          ld_end  = fin;
          ld_last = fin && !cur.ev;
          if (fin) begin
            state_next = cur.ev ? S_EVENT : S_IDLE;
            we         = cur.wr;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      S_EVENT: begin
        if (can_load) begin
          load       = 1'b1;
          ld_kind    = cur.ekind;
          ld_status  = cur.estatus;
          ld_end     = 1'b1;
          ld_last    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (load) begin
      kind      <= ld_kind;
      has_char  <= ld_has;
      out_char  <= ld_char;
      token_end <= ld_end;
      status    <= ld_status;
      last      <= ld_last;
    end
  end

endmodule

// ----- hdl/markup_tag_tokenizer.sv -----
// Top level of the markup tag tokenizer: front end, command queue and back end.
// An input word is taken while the two-entry command queue has room.
// The back end handles one command at a time: it stores a character, or it starts a drain from
// idle and gives one result word per cycle while the output is not stalled, then any following event.
// A word's first result goes through the command queue, the back-end state and the output register.
// Reset clears the parse mode, fill count, queue and output valid; buffer contents are not cleared.
module markup_tag_tokenizer import mtt_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic       has_char,
  output logic [7:0] out_char,
  output logic       token_end,
  output logic [1:0] status,
  output logic       last
);

  logic q_push;
  cmd_t q_wdata;
  logic q_full;
  logic q_pop;
  cmd_t q_rdata;
  logic q_valid;

  mtt_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .in_char  (in_char),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  mtt_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .pop_valid (q_valid)
  );

  mtt_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .has_char  (has_char),
    .out_char  (out_char),
    .token_end (token_end),
    .status    (status),
    .last      (last)
  );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the markup tag tokenizer: byte stimulus, token prediction, checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mtt_pkg::*;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;
  localparam int TOKEN_CAP = BUFFER_DEPTH_DEF - 1;
  localparam int DRAIN_LIMIT = 200000;
  localparam int TAIL_CYCLES = 80;

  typedef enum logic [2:0] {
    PM_TEXT  = 3'd0,
    PM_TAG   = 3'd1,
    PM_ATTR  = 3'd2,
    PM_CLOSE = 3'd3,
    PM_VALUE = 3'd4
  } parse_mode_e;

  typedef struct packed {
    logic [2:0] kind;
    logic       has_char;
    logic [7:0] out_char;
    logic       token_end;
    logic [1:0] status;
    logic       last;
  } token_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       cmd = 1'b0;
  logic [7:0] in_char = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] kind;
  logic       has_char;
  logic [7:0] out_char;
  logic       token_end;
  logic [1:0] status;
  logic       last;

  parse_mode_e tok_mode = PM_TEXT;
  logic [7:0]  tok_buf [BUFFER_DEPTH_DEF];
  int unsigned tok_fill = 0;
  int          item_results;
  token_word_t pending_words [$];

  logic [7:0] specials [5] = '{CH_LT, CH_SLASH, CH_GT, CH_SPACE, CH_EQ};

  int idle_max = 5;
  int out_wait = 0;
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int tags_done = 0;
  int status_seen = 0;

  markup_tag_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .in_char   (in_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .has_char  (has_char),
    .out_char  (out_char),
    .token_end (token_end),
    .status    (status),
    .last      (last)
  );

  always #2 clk = ~clk;

  function automatic void emit(logic [2:0] k, logic h, logic [7:0] ch, logic e, logic [1:0] st);
    token_word_t w;
    w.kind = k;
    w.has_char = h;
    w.out_char = ch;
    w.token_end = e;
    w.status = st;
    w.last = 1'b0;
    pending_words.push_back(w);
    item_results++;
  endfunction

  function automatic void drain_token(logic [2:0] k);
    int unsigned n;
    n = (tok_fill > TOKEN_CAP) ? TOKEN_CAP : tok_fill;
    if (n == 0) begin
      emit(k, 1'b0, 8'h00, 1'b1, ST_CLEAN);
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        emit(k, 1'b1, tok_buf[i], (i + 1 == n), ST_CLEAN);
      end
    end
    tok_fill = 0;
  endfunction

  function automatic void store_char(logic [7:0] ch);
    if (tok_fill >= TOKEN_CAP) begin
      emit(K_STATUS, 1'b0, 8'h00, 1'b1, ST_OVER);
    end else begin
      tok_buf[tok_fill] = ch;
      tok_fill++;
    end
  endfunction

  function automatic void tokenize_word(logic c, logic [7:0] ch);
    token_word_t w;
    item_results = 0;
    if (c == CMD_END) begin
      if (tok_mode != PM_TEXT) begin
        emit(K_STATUS, 1'b0, 8'h00, 1'b1, ST_UNEXP);
      end else begin
        if (tok_fill != 0) drain_token(K_TEXT);
        emit(K_STATUS, 1'b0, 8'h00, 1'b1, ST_CLEAN);
        tok_fill = 0;
      end
    end else begin
      case (tok_mode)
        PM_TEXT: begin
          if (tok_fill >= TOKEN_CAP) drain_token(K_TEXT);
          if (ch == CH_LT) begin
            if (tok_fill != 0) drain_token(K_TEXT);
            tok_mode = PM_TAG;
          end else begin
            store_char(ch);
          end
        end
        PM_TAG: begin
          if (ch == CH_SLASH) begin
            if (tok_fill != 0) emit(K_STATUS, 1'b0, 8'h00, 1'b1, ST_SYNTAX);
            else tok_mode = PM_CLOSE;
          end else if (ch == CH_GT) begin
            drain_token(K_NAME);
            emit(K_DONE, 1'b0, 8'h00, 1'b1, ST_CLEAN);
            tok_mode = PM_TEXT;
          end else if (ch == CH_SPACE) begin
            drain_token(K_NAME);
            tok_mode = PM_ATTR;
          end else begin
            store_char(ch);
          end
        end
        PM_ATTR: begin
          if (ch == CH_SPACE) begin
            drain_token(K_BARE);
          end else if (ch == CH_GT) begin
            drain_token(K_BARE);
            emit(K_DONE, 1'b0, 8'h00, 1'b1, ST_CLEAN);
            tok_mode = PM_TEXT;
          end else if (ch == CH_EQ) begin
            drain_token(K_ATTR);
            tok_mode = PM_VALUE;
          end else begin
            store_char(ch);
          end
        end
        PM_CLOSE: begin
          if (ch == CH_GT) begin
            drain_token(K_CLOSE);
            tok_mode = PM_TEXT;
          end else begin
            store_char(ch);
          end
        end
        PM_VALUE: begin
          if (ch == CH_SPACE) begin
            drain_token(K_VALUE);
            tok_mode = PM_ATTR;
          end else if (ch == CH_GT) begin
            drain_token(K_VALUE);
            emit(K_DONE, 1'b0, 8'h00, 1'b1, ST_CLEAN);
            tok_mode = PM_TEXT;
          end else begin
            store_char(ch);
          end
        end
        default: begin
          emit(K_STATUS, 1'b0, 8'h00, 1'b1, ST_SYNTAX);
          tok_mode = PM_TEXT;
          tok_fill = 0;
        end
      endcase
    end
    if (item_results > 0) begin
      w = pending_words.pop_back();
      w.last = 1'b1;
      pending_words.push_back(w);
    end
  endfunction

  task automatic check_field(string fname, logic [7:0] exp_val, logic [7:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, fname, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    token_word_t w;
    if (rst) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        results_seen++;
        if (pending_words.size() == 0) begin
          errors++;
          $display("%0t: no word expected, got kind %0d char %0h status %0d", $time, kind,
                   out_char, status);
        end else begin
          w = pending_words.pop_front();
          check_field("kind", 8'(w.kind), 8'(kind));
          check_field("has_char", 8'(w.has_char), 8'(has_char));
          check_field("out_char", w.out_char, out_char);
          check_field("token_end", 8'(w.token_end), 8'(token_end));
          check_field("status", 8'(w.status), 8'(status));
          check_field("last", 8'(w.last), 8'(last));
          if (w.kind == K_DONE) tags_done++;
          if (w.kind == K_STATUS) status_seen++;
        end
        out_wait = $urandom_range(0, idle_max);
      end
      if (out_wait > 0) begin
        out_stall <= 1'b1;
        out_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(logic c, logic [7:0] ch);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    in_char <= ch;
    tokenize_word(c, ch);
    words_sent++;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255));
    while (ch == CH_LT || ch == CH_SLASH || ch == CH_GT || ch == CH_SPACE || ch == CH_EQ);
    return ch;
  endfunction

  task automatic send_plain(int n);
    repeat (n) send_word(CMD_CHAR, plain_char());
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(CMD_CHAR, s[i]);
  endtask

  task automatic test_directed();
    idle_max = 0;
    send_word(CMD_CHAR, 8'h00);
    send_word(CMD_CHAR, 8'hFF);
    send_word(CMD_END, 8'hFF);
    idle_max = 5;
    send_text("<b c=d e f=g>");
    send_text("<>");
    send_text("</>");
    send_text("<ab/");
    send_word(CMD_END, 8'h00);
    send_word(CMD_CHAR, CH_GT);
    send_word(CMD_END, 8'h5A);
  endtask

  task automatic test_text_flush();
    idle_max = 2;
    send_plain(70);
    send_text("<>");
    send_word(CMD_END, 8'h00);
  endtask

  task automatic test_tag_overflow();
    idle_max = 3;
    send_word(CMD_CHAR, CH_LT);
    send_plain(66);
    send_word(CMD_CHAR, CH_GT);
  endtask

  task automatic send_markup();
    int shape;
    send_plain($urandom_range(0, 6));
    send_word(CMD_CHAR, CH_LT);
    shape = $urandom_range(0, 19);
    if (shape < 4) begin
      send_word(CMD_CHAR, CH_SLASH);
      send_plain($urandom_range(0, 5));
      send_word(CMD_CHAR, CH_GT);
    end else begin
      send_plain((shape == 4) ? $urandom_range(60, 68) : $urandom_range(0, 5));
      if (shape == 5) send_word(CMD_CHAR, CH_SLASH);
      repeat ($urandom_range(0, 3)) begin
        send_word(CMD_CHAR, CH_SPACE);
        send_plain($urandom_range(0, 4));
        if ($urandom_range(0, 1) == 1) begin
          send_word(CMD_CHAR, CH_EQ);
          send_plain((shape == 6) ? $urandom_range(60, 68) : $urandom_range(0, 4));
        end
      end
      if (shape == 7) send_word(CMD_END, 8'($urandom_range(0, 255)));
      send_word(CMD_CHAR, CH_GT);
    end
    if ($urandom_range(0, 9) == 0) send_word(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_word(CMD_END, 8'($urandom_range(0, 255)));
      else if (r < 6) send_word(CMD_CHAR, specials[$urandom_range(0, 4)]);
      else send_word(CMD_CHAR, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_markup();
    int start_count;
    start_count = words_sent;
    while (words_sent - start_count < 40) begin
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 8));
      else send_markup();
    end
  endtask

  initial begin
    int waited;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_text_flush();
    test_tag_overflow();
    test_random_markup();
    in_valid <= 1'b0;
    waited = 0;
    while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, pending_words.size());
    end
    $display("Sent %0d input words; checked %0d result words, %0d tags completed, %0d status.",
             words_sent, results_seen, tags_done, status_seen);
    if (errors == 0) begin
      $display("markup_tag_tokenizer: match");
    end else begin
      $display("markup_tag_tokenizer: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Run stopped by the time limit with %0d words outstanding.", pending_words.size());
    $display("markup_tag_tokenizer: mismatch");
    $finish;
  end

endmodule
